### hdl/dfa_token_scanner_macros.svh
// Assertion macros for the DFA token scanner.
`ifndef DFA_TOKEN_SCANNER_MACROS_SVH
`define DFA_TOKEN_SCANNER_MACROS_SVH

// Check that c holds in the same cycle as a.
`define DTS_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("dfa_token_scanner: same-cycle check failed");

// Check that c holds in the cycle after a.
`define DTS_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("dfa_token_scanner: next-cycle check failed");

`endif

### hdl/dts_pkg.sv
// Shared types and constants for the DFA token scanner.
package dts_pkg;

    localparam int DEF_STATES        = 64;
    localparam int DEF_RANGE_ENTRIES = 64;
    localparam int DEF_TEXT_BYTES    = 4096;
    localparam int DEF_SYMBOLS       = 256;
    localparam int ASCII_SPAN        = 128;

    localparam logic [2:0] OP_JUMP   = 3'd0;
    localparam logic [2:0] OP_RANGE  = 3'd1;
    localparam logic [2:0] OP_ACCEPT = 3'd2;
    localparam logic [2:0] OP_APPEND = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_END_SYM = 2'd1;
    localparam logic [1:0] CFG_ERR_SYM = 2'd2;
    localparam logic [1:0] CFG_NEWLINE = 2'd3;

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic signed [6:0] TGT_STOP   = -7'sd1;
    localparam logic signed [6:0] TGT_EXTEND = -7'sd2;
    localparam logic signed [6:0] TGT_SKIP   = -7'sd3;

    typedef struct packed {
        logic jump_we;
        logic range_we;
        logic accept_we;
    } tbl_wr_t;

endpackage

### hdl/dts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/dts_tables.sv
// Jump, accept and range tables with valid bits and the jump-table clearing pass.
module dts_tables #(
    parameter int STATES        = dts_pkg::DEF_STATES,
    parameter int RANGE_ENTRIES = dts_pkg::DEF_RANGE_ENTRIES,
    parameter int SYMBOLS       = dts_pkg::DEF_SYMBOLS
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  dts_pkg::tbl_wr_t                          wr,
    input  logic [5:0]                                state_index,
    input  logic [6:0]                                char_idx,
    input  logic signed [6:0]                         next_state,
    input  logic signed [8:0]                         accepted_symbol,
    input  logic [5:0]                                range_slot,
    input  logic [15:0]                               range_low,
    input  logic [15:0]                               range_high,
    input  logic [$clog2(STATES)+6:0]                 jt_raddr,
    input  logic [$clog2(STATES)-1:0]                 acc_raddr,
    input  logic [(RANGE_ENTRIES > 1 ? $clog2(RANGE_ENTRIES) : 1)-1:0] rng_raddr,
    output logic signed [6:0]                         jt_q,
    output logic                                      acc_has_q,
    output logic [7:0]                                acc_sym_q,
    output logic                                      rng_vld_q,
    output logic [5:0]                                rng_state_q,
    output logic [15:0]                               rng_low_q,
    output logic [15:0]                               rng_high_q,
    output logic signed [6:0]                         rng_tgt_q,
    output logic                                      clr_busy
);
    import dts_pkg::*;

    localparam int ST_AW    = $clog2(STATES);
    localparam int JT_AW    = ST_AW + 7;
    localparam int JT_DEPTH = STATES * ASCII_SPAN;
    localparam int RA_W     = RANGE_ENTRIES > 1 ? $clog2(RANGE_ENTRIES) : 1;

    logic [JT_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_busy_reg, clr_busy_next;
    logic             jt_we;
    logic [JT_AW-1:0] jt_waddr;
    logic [6:0]       jt_wdata;
    logic [6:0]       jt_rdata;

    logic             acc_valid_reg [STATES];
    logic             acc_vld_reg;
    logic [8:0]       acc_wdata, acc_rdata;
    logic             acc_has_w;

    logic             rng_valid_reg [RANGE_ENTRIES];
    logic [44:0]      rng_wdata, rng_rdata;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == JT_AW'(JT_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign clr_busy = clr_busy_reg;
    assign jt_we    = clr_busy_reg || wr.jump_we;
    assign jt_waddr = clr_busy_reg ? clr_cnt_reg : {ST_AW'(state_index), char_idx};
    assign jt_wdata = clr_busy_reg ? TGT_STOP : next_state;

    dts_ram #(.WIDTH(7), .DEPTH(JT_DEPTH)) u_jump (
        .clk   (clk),
        .we    (jt_we),
        .waddr (jt_waddr),
        .wdata (jt_wdata),
        .raddr (jt_raddr),
        .rdata (jt_rdata)
    );
    assign jt_q = jt_rdata;

    assign acc_has_w = (accepted_symbol >= 0) && (int'(accepted_symbol) < SYMBOLS);
    assign acc_wdata = {acc_has_w, accepted_symbol[7:0]};

    dts_ram #(.WIDTH(9), .DEPTH(STATES)) u_accept (
        .clk   (clk),
        .we    (wr.accept_we),
        .waddr (ST_AW'(state_index)),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    assign rng_wdata = {state_index, range_low, range_high, next_state};

    dts_ram #(.WIDTH(45), .DEPTH(RANGE_ENTRIES)) u_range (
        .clk   (clk),
        .we    (wr.range_we),
        .waddr (RA_W'(range_slot)),
        .wdata (rng_wdata),
        .raddr (rng_raddr),
        .rdata (rng_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATES; i++)
            begin
                acc_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < RANGE_ENTRIES; i++)
            begin
                rng_valid_reg[i] <= 1'b0;
            end
            acc_vld_reg <= 1'b0;
            rng_vld_q   <= 1'b0;
        end
        else
        begin
            if (wr.accept_we)
            begin
                acc_valid_reg[ST_AW'(state_index)] <= 1'b1;
            end
            if (wr.range_we)
            begin
                rng_valid_reg[RA_W'(range_slot)] <= 1'b1;
            end
            acc_vld_reg <= (int'(acc_raddr) < STATES) && acc_valid_reg[acc_raddr];
            rng_vld_q   <= (int'(rng_raddr) < RANGE_ENTRIES) && rng_valid_reg[rng_raddr];
        end
    end

    assign acc_has_q   = acc_vld_reg && acc_rdata[8];
    assign acc_sym_q   = acc_rdata[7:0];
    assign rng_state_q = rng_rdata[44:39];
    assign rng_low_q   = rng_rdata[38:23];
    assign rng_high_q  = rng_rdata[22:7];
    assign rng_tgt_q   = rng_rdata[6:0];
endmodule

### hdl/dfa_token_scanner.sv
// Top level of the DFA token scanner: configuration, scan sequencer, text store, output.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  opcode .. range_high
//   out       output     out_valid / out_stall token_kind .. token_column
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Load items are taken while in_stall is low. A read fetches each lead byte: ASCII goes
// to the jump table; non-ASCII has continuation bytes decoded and range slots searched.
// Each state entered reads the accept table; the cursor then steps over the token byte
// by byte on the single text read port. After reset all STATES*128 jump-table entries
// (8192 by default) are set to stop, in_stall high meanwhile. The result waits in an
// output register; a stall there holds the sequencer only when the next result is ready.
`include "dfa_token_scanner_macros.svh"

module dfa_token_scanner #(
    parameter int STATES        = dts_pkg::DEF_STATES,
    parameter int RANGE_ENTRIES = dts_pkg::DEF_RANGE_ENTRIES,
    parameter int TEXT_BYTES    = dts_pkg::DEF_TEXT_BYTES,
    parameter int SYMBOLS       = dts_pkg::DEF_SYMBOLS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [5:0]         state_index,
    input  logic [7:0]         char_or_byte,
    input  logic signed [6:0]  next_state,
    input  logic signed [8:0]  accepted_symbol,
    input  logic [5:0]         range_slot,
    input  logic [15:0]        range_low,
    input  logic [15:0]        range_high,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         token_kind,
    output logic [7:0]         symbol_id,
    output logic [11:0]        token_start,
    output logic [12:0]        token_length,
    output logic [15:0]        token_line,
    output logic [15:0]        token_column,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import dts_pkg::*;

    localparam int ST_AW = $clog2(STATES);
    localparam int JT_AW = ST_AW + 7;
    localparam int RA_W  = RANGE_ENTRIES > 1 ? $clog2(RANGE_ENTRIES) : 1;
    localparam int TA_W  = $clog2(TEXT_BYTES);
    localparam int TL_W  = TA_W + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FETCH  = 4'd1;
    localparam logic [3:0] S_LEAD   = 4'd2;
    localparam logic [3:0] S_CONT1  = 4'd3;
    localparam logic [3:0] S_CONT2  = 4'd4;
    localparam logic [3:0] S_RSRCH  = 4'd5;
    localparam logic [3:0] S_JUMP   = 4'd6;
    localparam logic [3:0] S_ACC    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;
    localparam logic [3:0] S_ADV    = 4'd9;
    localparam logic [3:0] S_ADV2   = 4'd10;

    logic [5:0]  start_reg;
    logic [7:0]  end_sym_reg, err_sym_reg, newline_reg;

    logic [3:0]      state_reg, state_next;
    logic [TL_W-1:0] text_len_reg, text_len_next;
    logic [TL_W-1:0] cursor_reg, cursor_next;
    logic [TL_W-1:0] cur_reg, cur_next;
    logic [TL_W-1:0] hit_cur_reg, hit_cur_next;
    logic [TL_W-1:0] nxt_reg, nxt_next;
    logic [15:0]     line_reg, line_next;
    logic [15:0]     col_reg, col_next;
    logic [5:0]      st_reg, st_next;
    logic            st_ok_reg, st_ok_next;
    logic            hit_vld_reg, hit_vld_next;
    logic [7:0]      hit_sym_reg, hit_sym_next;
    logic [7:0]      lead_reg, lead_next;
    logic [5:0]      b1_reg, b1_next;
    logic [15:0]     cp_reg, cp_next;
    logic            ascii_reg, ascii_next;
    logic [RA_W-1:0] rk_reg, rk_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      kind_reg, kind_next;
    logic [7:0]      sym_reg, sym_next;
    logic [11:0]     start_out_reg, start_out_next;
    logic [12:0]     len_out_reg, len_out_next;
    logic [15:0]     line_out_reg, line_out_next;
    logic [15:0]     col_out_reg, col_out_next;

    logic            in_acc;
    tbl_wr_t         tbl_wr;
    logic            clr_busy;
    logic            text_we;
    logic [TA_W-1:0] text_raddr;
    logic [7:0]      text_q;
    logic [JT_AW-1:0] jt_raddr;
    logic [ST_AW-1:0] acc_raddr;
    logic [RA_W-1:0] rng_raddr;
    logic signed [6:0] jt_q, rng_tgt_q;
    logic            acc_has_q, rng_vld_q;
    logic [7:0]      acc_sym_q;
    logic [5:0]      rng_state_q;
    logic [15:0]     rng_low_q, rng_high_q;

    logic signed [6:0] t_apply;
    logic            rng_match;
    logic [TL_W-1:0] cur_p1, cur_p2, cur_p3, cur_p4;
    logic [TL_W-1:0] res_next;
    logic [7:0]      cont_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            end_sym_reg <= 8'd0;
            err_sym_reg <= 8'd1;
            newline_reg <= 8'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START:   start_reg   <= cfg_data[5:0];
                CFG_END_SYM: end_sym_reg <= cfg_data;
                CFG_ERR_SYM: err_sym_reg <= cfg_data;
                CFG_NEWLINE: newline_reg <= cfg_data;
                default:     start_reg   <= start_reg;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE) || clr_busy;
    assign in_acc   = in_valid && !in_stall;

    assign tbl_wr.jump_we   = in_acc && (opcode == OP_JUMP) && !char_or_byte[7]
                              && (int'(state_index) < STATES);
    assign tbl_wr.range_we  = in_acc && (opcode == OP_RANGE)
                              && (int'(range_slot) < RANGE_ENTRIES)
                              && (int'(state_index) < STATES);
    assign tbl_wr.accept_we = in_acc && (opcode == OP_ACCEPT)
                              && (int'(state_index) < STATES);
    assign text_we = in_acc && (opcode == OP_APPEND) && (int'(text_len_reg) < TEXT_BYTES);

    dts_tables #(
        .STATES        (STATES),
        .RANGE_ENTRIES (RANGE_ENTRIES),
        .SYMBOLS       (SYMBOLS)
    ) u_tables (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr              (tbl_wr),
        .state_index     (state_index),
        .char_idx        (char_or_byte[6:0]),
        .next_state      (next_state),
        .accepted_symbol (accepted_symbol),
        .range_slot      (range_slot),
        .range_low       (range_low),
        .range_high      (range_high),
        .jt_raddr        (jt_raddr),
        .acc_raddr       (acc_raddr),
        .rng_raddr       (rng_raddr),
        .jt_q            (jt_q),
        .acc_has_q       (acc_has_q),
        .acc_sym_q       (acc_sym_q),
        .rng_vld_q       (rng_vld_q),
        .rng_state_q     (rng_state_q),
        .rng_low_q       (rng_low_q),
        .rng_high_q      (rng_high_q),
        .rng_tgt_q       (rng_tgt_q),
        .clr_busy        (clr_busy)
    );

    dts_ram #(.WIDTH(8), .DEPTH(TEXT_BYTES)) u_text (
        .clk   (clk),
        .we    (text_we),
        .waddr (TA_W'(text_len_reg)),
        .wdata (char_or_byte),
        .raddr (text_raddr),
        .rdata (text_q)
    );

    assign cur_p1 = cur_reg + TL_W'(1);
    assign cur_p2 = cur_reg + TL_W'(2);
    assign cur_p3 = cur_reg + TL_W'(3);
    assign cur_p4 = cur_reg + TL_W'(4);

    always_comb
    begin
        unique case (state_reg)
            S_LEAD:  text_raddr = TA_W'(cur_p1);
            S_CONT1: text_raddr = TA_W'(cur_p2);
            S_ADV:   text_raddr = TA_W'(cursor_reg);
            default: text_raddr = TA_W'(cur_reg);
        endcase
    end

    assign jt_raddr  = {ST_AW'(st_reg), text_q[6:0]};
    assign rng_raddr = (state_reg == S_RSRCH) ? RA_W'(rk_reg + 1'b1) : '0;
    assign rng_match = rng_vld_q && (rng_state_q == st_reg)
                       && (cp_reg >= rng_low_q) && (cp_reg <= rng_high_q);
    assign t_apply   = (state_reg == S_JUMP) ? (st_ok_reg ? jt_q : TGT_STOP)
                                             : (rng_match ? rng_tgt_q : TGT_STOP);
    assign acc_raddr = ST_AW'(t_apply[5:0]);

    always_comb
    begin
        if (state_reg == S_CONT1)
        begin
            cont_byte = (cur_p1 < text_len_reg) ? text_q : 8'd0;
        end
        else
        begin
            cont_byte = (cur_p2 < text_len_reg) ? text_q : 8'd0;
        end
    end

    always_comb
    begin
        if (hit_vld_reg)
        begin
            res_next = hit_cur_reg;
        end
        else
        begin
            res_next = cur_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        text_len_next  = text_len_reg;
        cursor_next    = cursor_reg;
        cur_next       = cur_reg;
        hit_cur_next   = hit_cur_reg;
        nxt_next       = nxt_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        st_next        = st_reg;
        st_ok_next     = st_ok_reg;
        hit_vld_next   = hit_vld_reg;
        hit_sym_next   = hit_sym_reg;
        lead_next      = lead_reg;
        b1_next        = b1_reg;
        cp_next        = cp_reg;
        ascii_next     = ascii_reg;
        rk_next        = rk_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        sym_next       = sym_reg;
        start_out_next = start_out_reg;
        len_out_next   = len_out_reg;
        line_out_next  = line_out_reg;
        col_out_next   = col_out_reg;

        if (text_we)
        begin
            text_len_next = text_len_reg + 1'b1;
        end

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_acc && (opcode == OP_READ))
                begin
                    st_next      = start_reg;
                    cur_next     = cursor_reg;
                    hit_vld_next = 1'b0;
                    hit_cur_next = cursor_reg;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                rk_next = '0;
                if (cur_reg >= text_len_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_LEAD;
                end
            end
            S_LEAD:
            begin
                if (!text_q[7])
                begin
                    ascii_next = 1'b1;
                    st_ok_next = int'(st_reg) < STATES;
                    cur_next   = cur_p1;
                    state_next = S_JUMP;
                end
                else
                begin
                    ascii_next = 1'b0;
                    lead_next  = text_q;
                    if (text_q >= 8'hF0)
                    begin
                        cp_next    = 16'hFFFF;
                        cur_next   = (cur_p4 > text_len_reg) ? text_len_reg : cur_p4;
                        state_next = S_RSRCH;
                    end
                    else
                    begin
                        state_next = S_CONT1;
                    end
                end
            end
            S_CONT1:
            begin
                if (lead_reg < 8'hE0)
                begin
                    cp_next    = {5'd0, lead_reg[4:0], cont_byte[5:0]};
                    cur_next   = (cur_p2 > text_len_reg) ? text_len_reg : cur_p2;
                    state_next = S_RSRCH;
                end
                else
                begin
                    b1_next    = cont_byte[5:0];
                    state_next = S_CONT2;
                end
            end
            S_CONT2:
            begin
                cp_next    = {lead_reg[3:0], b1_reg, cont_byte[5:0]};
                cur_next   = (cur_p3 > text_len_reg) ? text_len_reg : cur_p3;
                state_next = S_RSRCH;
            end
            S_RSRCH, S_JUMP:
            begin
                if ((state_reg == S_RSRCH) && !rng_match
                    && (rk_reg != RA_W'(RANGE_ENTRIES - 1)))
                begin
                    rk_next = rk_reg + 1'b1;
                end
                else if (t_apply == TGT_SKIP)
                begin
                    state_next = S_FETCH;
                end
                else if (t_apply == TGT_EXTEND)
                begin
                    if (ascii_reg)
                    begin
                        hit_cur_next = cur_reg;
                    end
                    state_next = S_FETCH;
                end
                else if ((t_apply < 0) || (int'(t_apply) >= STATES))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    st_next    = t_apply[5:0];
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_has_q)
                begin
                    hit_vld_next = 1'b1;
                    hit_sym_next = acc_sym_q;
                    hit_cur_next = cur_reg;
                end
                state_next = S_FETCH;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (hit_vld_reg)
                    begin
                        kind_next = KIND_TOKEN;
                        sym_next  = hit_sym_reg;
                    end
                    else if (cur_reg == cursor_reg)
                    begin
                        kind_next = KIND_END;
                        sym_next  = end_sym_reg;
                    end
                    else
                    begin
                        kind_next = KIND_ERROR;
                        sym_next  = err_sym_reg;
                    end
                    start_out_next = (int'(cursor_reg) > 4095) ? 12'hFFF : 12'(cursor_reg);
                    len_out_next   = 13'(res_next - cursor_reg);
                    line_out_next  = line_reg;
                    col_out_next   = col_reg;
                    nxt_next       = res_next;
                    state_next     = S_ADV;
                end
            end
            S_ADV:
            begin
                if (cursor_reg == nxt_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ADV2;
                end
            end
            S_ADV2:
            begin
                if (text_q == newline_reg)
                begin
                    if (line_reg != 16'hFFFF)
                    begin
                        line_next = line_reg + 1'b1;
                    end
                    col_next = 16'd1;
                end
                else if (col_reg != 16'hFFFF)
                begin
                    col_next = col_reg + 1'b1;
                end
                cursor_next = cursor_reg + 1'b1;
                state_next  = S_ADV;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            text_len_reg  <= '0;
            cursor_reg    <= '0;
            line_reg      <= 16'd1;
            col_reg       <= 16'd1;
            out_valid_reg <= 1'b0;
            hit_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            text_len_reg  <= text_len_next;
            cursor_reg    <= cursor_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            hit_vld_reg   <= hit_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        hit_cur_reg   <= hit_cur_next;
        nxt_reg       <= nxt_next;
        st_reg        <= st_next;
        st_ok_reg     <= st_ok_next;
        hit_sym_reg   <= hit_sym_next;
        lead_reg      <= lead_next;
        b1_reg        <= b1_next;
        cp_reg        <= cp_next;
        ascii_reg     <= ascii_next;
        rk_reg        <= rk_next;
        kind_reg      <= kind_next;
        sym_reg       <= sym_next;
        start_out_reg <= start_out_next;
        len_out_reg   <= len_out_next;
        line_out_reg  <= line_out_next;
        col_out_reg   <= col_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign token_kind   = kind_reg;
    assign symbol_id    = sym_reg;
    assign token_start  = start_out_reg;
    assign token_length = len_out_reg;
    assign token_line   = line_out_reg;
    assign token_column = col_out_reg;

    `DTS_ASSERT_IMPL(a_cursor_in_text, 1'b1, cursor_reg <= text_len_reg)
    `DTS_ASSERT_IMPL(a_end_is_empty, out_valid && (token_kind == KIND_END), token_length == 13'd0)
    `DTS_ASSERT_IMPL(a_stall_while_clear, clr_busy, in_stall)
    `DTS_ASSERT_NEXT(a_done_loads_out, (state_reg == S_DONE) && !out_valid_reg, out_valid_reg)
endmodule
